@@ rtl/hmts_pkg.sv @@
package hmts_pkg;

    // widths fixed by the item and register formats
    localparam int DIM_W     = 7;
    localparam int DIM_LIMIT = (1 << DIM_W) - 1;
    localparam int IDX_W     = 13;
    localparam int ADDR_W    = 14;
    localparam int DATA_W    = 32;

    // command queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // opcodes carried in tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // configuration register indexes
    localparam logic CFG_GRID_WIDTH  = 1'b0;
    localparam logic CFG_GRID_HEIGHT = 1'b1;

    typedef struct packed {
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
    } t_dims;

    // one queued operation: a grid write or a classified query
    typedef struct packed {
        logic              query;
        logic              direct;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic [DATA_W-1:0] frac_y;
    } t_cmd;

endpackage

@@ rtl/heightmap_triangle_sampler_core.sv @@
// query path: queue slot, grid read, candidates, diagonal choice, products, output register
// one item per cycle unless the output stalls; writes give no result, take one pipeline slot
// the 4-entry command queue lets input transfers continue while a result waits
// reset clears queue, pipeline valid flags and sets both dimensions to 64 (clamped)
// grid contents are not cleared by reset
module heightmap_triangle_sampler_core #(
    parameter int GRID_MAX  = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave stream: items in
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // tdata: write_index[12:0], write_value[44:13], query_x[76:45], query_y[108:77], zero pad
    input  logic [111:0] i_s_axis_tdata,
    // tuser: opcode[0]
    input  logic         i_s_axis_tuser,
    // master stream: results out
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // tdata: altitude[31:0]
    output logic [31:0]  o_m_axis_tdata,
    // configuration write channel
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [6:0]   i_cfg_data
);
    import hmts_pkg::*;

    localparam int MAX_DIM = (GRID_MAX < DIM_LIMIT) ? GRID_MAX : DIM_LIMIT;
    localparam logic [DIM_W-1:0] MAX_DIM_V   = DIM_W'(MAX_DIM);
    localparam logic [DIM_W-1:0] RESET_DIM_V = DIM_W'((64 < MAX_DIM) ? 64 : MAX_DIM);

    t_dims             r_dims;
    logic [DIM_W-1:0]  cfg_sat;
    logic              cfg_fire;

    // front to queue
    logic              q_push;
    t_cmd              q_in;
    logic              q_full;
    // queue to back
    logic              q_pop;
    t_cmd              q_head;
    logic              q_empty;

    // dimensions are kept already saturated into 1..MAX_DIM (GRID_MAX, at most 127)
    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_sat = DIM_W'(1);
        end else if (i_cfg_data > MAX_DIM_V) begin
            cfg_sat = MAX_DIM_V;
        end else begin
            cfg_sat = i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims.w <= RESET_DIM_V;
            r_dims.h <= RESET_DIM_V;
        end else if (cfg_fire) begin
            case (i_cfg_index)
                CFG_GRID_WIDTH:  r_dims.w <= cfg_sat;
                CFG_GRID_HEIGHT: r_dims.h <= cfg_sat;
                default:         r_dims   <= r_dims;
            endcase
        end
    end

    // front: classify the item, check write range, form the base node address
    hmts_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_dims   (r_dims),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_opcode (i_s_axis_tuser),
        .i_index  (i_s_axis_tdata[12:0]),
        .i_value  (i_s_axis_tdata[44:13]),
        .i_qx     (i_s_axis_tdata[76:45]),
        .i_qy     (i_s_axis_tdata[108:77]),
        .i_full   (q_full),
        .o_push   (q_push),
        .o_cmd    (q_in)
    );

    // short queue decouples input transfers from back-end stalls
    hmts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // back: grid storage, corner reads, diagonal choice, blend
    hmts_back #(
        .GRID_MAX  (GRID_MAX),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_dims     (r_dims),
        .i_empty    (q_empty),
        .i_head     (q_head),
        .o_pop      (q_pop),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_altitude (o_m_axis_tdata)
    );

endmodule

@@ rtl/hmts_front.sv @@
module hmts_front #(
    parameter int FRAC_BITS = 16
) (
    input  hmts_pkg::t_dims                   i_dims,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_opcode,
    input  logic [hmts_pkg::IDX_W-1:0]        i_index,
    input  logic [hmts_pkg::DATA_W-1:0]       i_value,
    input  logic signed [hmts_pkg::DATA_W-1:0] i_qx,
    input  logic signed [hmts_pkg::DATA_W-1:0] i_qy,
    input  logic                              i_full,
    output logic                              o_push,
    output hmts_pkg::t_cmd                    o_cmd
);
    import hmts_pkg::*;

    localparam logic [DATA_W-1:0] FRAC_MASK = (DATA_W'(1) << FRAC_BITS) - DATA_W'(1);

    logic [DIM_W:0]          stride;
    logic [DIM_W:0]          rows;
    logic [2*DIM_W+1:0]      node_cnt;
    logic                    write_ok;
    logic signed [DATA_W-1:0] ix;
    logic signed [DATA_W-1:0] iy;
    logic [DIM_W-1:0]        cx;
    logic [DIM_W-1:0]        cy;
    logic signed [39:0]      qx_ext;
    logic signed [39:0]      qy_ext;
    logic signed [39:0]      lim_x;
    logic signed [39:0]      lim_y;
    logic [DATA_W-1:0]       xd;
    logic [DATA_W-1:0]       yd;
    logic                    border;
    logic [ADDR_W:0]         a0_full;

    always_comb begin
        stride   = {1'b0, i_dims.w} + (DIM_W+1)'(1);
        rows     = {1'b0, i_dims.h} + (DIM_W+1)'(1);
        node_cnt = stride * rows;
        write_ok = (2*DIM_W+2)'(i_index) < node_cnt;

        ix = i_qx >>> FRAC_BITS;
        iy = i_qy >>> FRAC_BITS;
        if (ix < 0) begin
            cx = '0;
        end else if (ix > $signed(DATA_W'(i_dims.w))) begin
            cx = i_dims.w;
        end else begin
            cx = ix[DIM_W-1:0];
        end
        if (iy < 0) begin
            cy = '0;
        end else if (iy > $signed(DATA_W'(i_dims.h))) begin
            cy = i_dims.h;
        end else begin
            cy = iy[DIM_W-1:0];
        end

        qx_ext = {{8{i_qx[DATA_W-1]}}, i_qx};
        qy_ext = {{8{i_qy[DATA_W-1]}}, i_qy};
        lim_x  = $signed(40'(i_dims.w) << FRAC_BITS);
        lim_y  = $signed(40'(i_dims.h) << FRAC_BITS);
        xd     = i_qx & FRAC_MASK;
        yd     = i_qy & FRAC_MASK;
        // border, outside, or exactly on a node: a single node read
        border = (qx_ext <= 40'sd0) || (qx_ext >= lim_x) ||
                 (qy_ext <= 40'sd0) || (qy_ext >= lim_y) ||
                 ((xd == '0) && (yd == '0));

        a0_full = (ADDR_W+1)'(cy) * (ADDR_W+1)'(stride) + (ADDR_W+1)'(cx);

        o_ready = !i_full;
        o_cmd   = '0;
        o_push  = 1'b0;
        case (i_opcode)
            OP_WRITE: begin
                o_cmd.query = 1'b0;
                o_cmd.addr  = ADDR_W'(i_index);
                o_cmd.data  = i_value;
                o_push      = i_valid && !i_full && write_ok;
            end
            OP_QUERY: begin
                o_cmd.query  = 1'b1;
                o_cmd.direct = border;
                o_cmd.addr   = a0_full[ADDR_W-1:0];
                o_cmd.data   = xd;
                o_cmd.frac_y = yd;
                o_push       = i_valid && !i_full;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/hmts_queue.sv @@
module hmts_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  hmts_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output hmts_pkg::t_cmd o_head,
    output logic           o_full,
    output logic           o_empty
);
    import hmts_pkg::*;

    t_cmd              r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;

    always_comb begin
        n_count = r_count;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + QCNT_W'(1);
            2'b01:   n_count = r_count - QCNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_head  = r_slot[r_rd_ptr];
    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == QCNT_W'(QDEPTH)) |-> !i_push)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> !i_pop)
        else $error("queue pop while empty");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + QCNT_W'(1)))
        else $error("queue count lost a push");
`endif

endmodule

@@ rtl/hmts_back.sv @@
module hmts_back #(
    parameter int GRID_MAX  = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  hmts_pkg::t_dims             i_dims,
    input  logic                        i_empty,
    input  hmts_pkg::t_cmd              i_head,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [hmts_pkg::DATA_W-1:0] o_altitude
);
    import hmts_pkg::*;

    localparam int MAX_DIM = (GRID_MAX < DIM_LIMIT) ? GRID_MAX : DIM_LIMIT;
    localparam int DEPTH   = (MAX_DIM + 1) * (MAX_DIM + 1);
    localparam int AW      = $clog2(DEPTH);
    localparam logic [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;

    logic              en;
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] stride;
    logic [ADDR_W-1:0] rd_addr [4];
    logic [DATA_W-1:0] rd_h [4];

    // read stage
    logic              r_rd_valid;
    logic              r_rd_direct;
    logic [DATA_W-1:0] r_rd_xd;
    logic [DATA_W-1:0] r_rd_yd;

    // triangle candidates for both diagonals
    logic [DATA_W-1:0] alt_a [3];
    logic [DATA_W-1:0] wgt_a [3];
    logic [DATA_W-1:0] alt_b [3];
    logic [DATA_W-1:0] wgt_b [3];
    logic signed [DATA_W:0] diff30;
    logic signed [DATA_W:0] diff21;
    logic              r_d_valid;
    logic [DATA_W-1:0] r_d_alt_a [3];
    logic [DATA_W-1:0] r_d_wgt_a [3];
    logic [DATA_W-1:0] r_d_alt_b [3];
    logic [DATA_W-1:0] r_d_wgt_b [3];
    logic signed [DATA_W:0] r_d_diff30;
    logic signed [DATA_W:0] r_d_diff21;

    // diagonal choice
    logic [DATA_W:0]   abs30;
    logic [DATA_W:0]   abs21;
    logic              pick_a;
    logic              r_s_valid;
    logic signed [DATA_W-1:0] r_s_alt [3];
    logic signed [DATA_W-1:0] r_s_wgt [3];

    // products and output
    logic              r_m_valid;
    logic signed [2*DATA_W-1:0] r_m_prod [3];
    logic [DATA_W-1:0] sum;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_alt;

    // whole pipeline moves unless a result waits at the output
    assign en    = !r_out_valid || i_ready;
    assign o_pop = en && !i_empty;
    assign wr_en = o_pop && !i_head.query;
    assign rd_en = o_pop && i_head.query;

    always_comb begin
        stride = ADDR_W'(i_dims.w) + ADDR_W'(1);
        if (i_head.direct) begin
            rd_addr[0] = i_head.addr;
            rd_addr[1] = i_head.addr;
            rd_addr[2] = i_head.addr;
            rd_addr[3] = i_head.addr;
        end else begin
            rd_addr[0] = i_head.addr;
            rd_addr[1] = i_head.addr + ADDR_W'(1);
            rd_addr[2] = i_head.addr + stride;
            rd_addr[3] = i_head.addr + stride + ADDR_W'(1);
        end
    end

    // four copies of the grid so all corners are read in the same cycle
    for (genvar k = 0; k < 4; k++) begin : g_bank
        logic [DATA_W-1:0] r_bank [DEPTH];
        logic [DATA_W-1:0] r_q;
        always_ff @(posedge i_clk) begin
            if (wr_en) begin
                r_bank[i_head.addr[AW-1:0]] <= i_head.data;
            end
            if (rd_en) begin
                r_q <= r_bank[rd_addr[k][AW-1:0]];
            end
        end
        assign rd_h[k] = r_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid  <= 1'b0;
            r_d_valid   <= 1'b0;
            r_s_valid   <= 1'b0;
            r_m_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_rd_valid  <= rd_en;
            r_d_valid   <= r_rd_valid;
            r_s_valid   <= r_d_valid;
            r_m_valid   <= r_s_valid;
            r_out_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rd_direct <= i_head.direct;
            r_rd_xd     <= i_head.data;
            r_rd_yd     <= i_head.frac_y;
        end
    end

    always_comb begin
        diff30 = $signed({rd_h[3][DATA_W-1], rd_h[3]}) - $signed({rd_h[0][DATA_W-1], rd_h[0]});
        diff21 = $signed({rd_h[2][DATA_W-1], rd_h[2]}) - $signed({rd_h[1][DATA_W-1], rd_h[1]});
        if (r_rd_direct) begin
            // node altitude passes through unchanged with weight one
            alt_a[0] = rd_h[0]; wgt_a[0] = ONE;
            alt_a[1] = rd_h[0]; wgt_a[1] = '0;
            alt_a[2] = rd_h[0]; wgt_a[2] = '0;
        end else if (r_rd_xd <= ONE - r_rd_yd) begin
            alt_a[0] = rd_h[0]; wgt_a[0] = ONE - r_rd_xd - r_rd_yd;
            alt_a[1] = rd_h[1]; wgt_a[1] = r_rd_xd;
            alt_a[2] = rd_h[2]; wgt_a[2] = r_rd_yd;
        end else begin
            alt_a[0] = rd_h[1]; wgt_a[0] = ONE - r_rd_yd;
            alt_a[1] = rd_h[3]; wgt_a[1] = r_rd_xd + r_rd_yd - ONE;
            alt_a[2] = rd_h[2]; wgt_a[2] = ONE - r_rd_xd;
        end
        if (r_rd_direct) begin
            alt_b[0] = rd_h[0]; wgt_b[0] = ONE;
            alt_b[1] = rd_h[0]; wgt_b[1] = '0;
            alt_b[2] = rd_h[0]; wgt_b[2] = '0;
        end else if (r_rd_xd <= r_rd_yd) begin
            alt_b[0] = rd_h[0]; wgt_b[0] = ONE - r_rd_yd;
            alt_b[1] = rd_h[3]; wgt_b[1] = r_rd_xd;
            alt_b[2] = rd_h[2]; wgt_b[2] = r_rd_yd - r_rd_xd;
        end else begin
            alt_b[0] = rd_h[0]; wgt_b[0] = ONE - r_rd_xd;
            alt_b[1] = rd_h[1]; wgt_b[1] = r_rd_xd - r_rd_yd;
            alt_b[2] = rd_h[3]; wgt_b[2] = r_rd_yd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_alt_a  <= alt_a;
            r_d_wgt_a  <= wgt_a;
            r_d_alt_b  <= alt_b;
            r_d_wgt_b  <= wgt_b;
            r_d_diff30 <= diff30;
            r_d_diff21 <= diff21;
        end
    end

    always_comb begin
        abs30  = r_d_diff30[DATA_W] ? (~r_d_diff30 + (DATA_W+1)'(1)) : r_d_diff30;
        abs21  = r_d_diff21[DATA_W] ? (~r_d_diff21 + (DATA_W+1)'(1)) : r_d_diff21;
        // ties split along the h1-h2 diagonal
        pick_a = (abs30 >= abs21);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_s_alt[k] <= pick_a ? r_d_alt_a[k] : r_d_alt_b[k];
                r_s_wgt[k] <= pick_a ? r_d_wgt_a[k] : r_d_wgt_b[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_m_prod[k] <= r_s_alt[k] * r_s_wgt[k];
            end
        end
    end

    // arithmetic shift by the fraction, then wrap to 32 bits
    assign sum = r_m_prod[0][FRAC_BITS +: DATA_W] + r_m_prod[1][FRAC_BITS +: DATA_W] +
                 r_m_prod[2][FRAC_BITS +: DATA_W];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_alt <= sum;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_altitude = r_out_alt;

`ifndef SYNTHESIS
    a_stall_holds_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> ($stable(r_m_valid) && $stable(r_s_valid)))
        else $error("pipeline moved during output stall");
    a_no_pop_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !(wr_en || rd_en))
        else $error("grid accessed during output stall");
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_altitude)))
        else $error("result changed during output stall");
`endif

endmodule

@@ verif/hmts_tb_pkg.sv @@
package hmts_tb_pkg;

    import hmts_pkg::*;

    localparam int GRID_MAX  = 64;
    localparam int FRAC_BITS = 16;
    localparam int NODES     = (GRID_MAX + 1) * (GRID_MAX + 1);
    localparam logic [DATA_W-1:0] ONE = 32'd1 << FRAC_BITS;

    // grid copy, sampler prediction and the queue of altitudes still owed by the block
    class altitude_scoreboard;

        logic [DATA_W-1:0] grid [NODES];
        bit                written [NODES];
        int                cells_x;
        int                cells_y;
        logic [DATA_W-1:0] altitude_q [$];
        int                errors;

        function new();
            cells_x = GRID_MAX;
            cells_y = GRID_MAX;
            errors  = 0;
        endfunction

        // register values saturate into 1..GRID_MAX
        function void set_dim(logic idx, logic [DIM_W-1:0] raw);
            int dim;
            dim = (raw < 1) ? 1 : ((raw > GRID_MAX) ? GRID_MAX : int'(raw));
            if (idx == CFG_GRID_WIDTH) cells_x = dim;
            else cells_y = dim;
        endfunction

        function int unsigned node_index(longint x, longint y);
            if (x < 0) x = 0;
            if (x > longint'(cells_x)) x = cells_x;
            if (y < 0) y = 0;
            if (y > longint'(cells_y)) y = cells_y;
            return int'(y) * (cells_x + 1) + int'(x);
        endfunction

        function longint height(longint x, longint y);
            return longint'($signed(grid[node_index(x, y)]));
        endfunction

        // border, outside or exactly on a node: answer is a single node
        function bit takes_node(logic signed [DATA_W-1:0] qx, logic signed [DATA_W-1:0] qy);
            longint sx;
            longint sy;
            sx = qx;
            sy = qy;
            return sx <= 0 || sx >= (longint'(cells_x) << FRAC_BITS) ||
                   sy <= 0 || sy >= (longint'(cells_y) << FRAC_BITS) ||
                   (qx[FRAC_BITS-1:0] == 0 && qy[FRAC_BITS-1:0] == 0);
        endfunction

        // grid entries that a query reads
        function void corner_nodes(logic signed [DATA_W-1:0] qx, logic signed [DATA_W-1:0] qy,
                                   output int unsigned nodes [$]);
            longint ix;
            longint iy;
            ix = longint'(qx) >>> FRAC_BITS;
            iy = longint'(qy) >>> FRAC_BITS;
            nodes = {};
            nodes.push_back(node_index(ix, iy));
            if (!takes_node(qx, qy)) begin
                nodes.push_back(node_index(ix + 1, iy));
                nodes.push_back(node_index(ix, iy + 1));
                nodes.push_back(node_index(ix + 1, iy + 1));
            end
        endfunction

        // altitude times weight, floor-shifted and wrapped to 32 bits
        function logic [DATA_W-1:0] scale(longint alt, logic [DATA_W-1:0] wgt);
            longint prod;
            prod = alt * longint'($signed(wgt));
            prod = prod >>> FRAC_BITS;
            return prod[DATA_W-1:0];
        endfunction

        function longint mag(longint v);
            return (v < 0) ? -v : v;
        endfunction

        function logic [DATA_W-1:0] sample(logic signed [DATA_W-1:0] qx,
                                           logic signed [DATA_W-1:0] qy);
            longint ix;
            longint iy;
            longint h0;
            longint h1;
            longint h2;
            longint h3;
            logic [DATA_W-1:0] xd;
            logic [DATA_W-1:0] yd;
            ix = longint'(qx) >>> FRAC_BITS;
            iy = longint'(qy) >>> FRAC_BITS;
            if (takes_node(qx, qy)) return grid[node_index(ix, iy)];
            xd = qx & (ONE - 1);
            yd = qy & (ONE - 1);
            h0 = height(ix, iy);
            h1 = height(ix + 1, iy);
            h2 = height(ix, iy + 1);
            h3 = height(ix + 1, iy + 1);
            // split along the flatter diagonal, ties go to h1-h2
            if (mag(h3 - h0) >= mag(h2 - h1)) begin
                if (xd <= ONE - yd)
                    return scale(h0, ONE - xd - yd) + scale(h1, xd) + scale(h2, yd);
                return scale(h1, ONE - yd) + scale(h3, xd + yd - ONE) + scale(h2, ONE - xd);
            end
            if (xd <= yd)
                return scale(h0, ONE - yd) + scale(h3, xd) + scale(h2, yd - xd);
            return scale(h0, ONE - xd) + scale(h1, xd - yd) + scale(h3, yd);
        endfunction

        function void note_item(logic op, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val,
                                logic [DATA_W-1:0] qx, logic [DATA_W-1:0] qy);
            if (op == OP_WRITE) begin
                if (int'(idx) < (cells_x + 1) * (cells_y + 1)) begin
                    grid[idx]    = val;
                    written[idx] = 1'b1;
                end
            end else begin
                altitude_q.push_back(sample(qx, qy));
            end
        endfunction

        function void check_result(logic [DATA_W-1:0] got);
            logic [DATA_W-1:0] want;
            if (altitude_q.size() == 0) begin
                $error("altitude: no result expected, actual %0d", $signed(got));
                errors++;
                return;
            end
            want = altitude_q.pop_front();
            if (got !== want) begin
                $error("altitude: expected %0d actual %0d", $signed(want), $signed(got));
                errors++;
            end
        endfunction

        function int pending();
            return altitude_q.size();
        endfunction

        function void finish();
            if (altitude_q.size() != 0) begin
                $error("altitude: %0d results never arrived", altitude_q.size());
                errors++;
            end
        endfunction

    endclass

endpackage

@@ verif/tb_heightmap_triangle_sampler_core.sv @@
module tb_heightmap_triangle_sampler_core;

    timeunit 1ns;
    timeprecision 1ps;

    import hmts_pkg::*;
    import hmts_tb_pkg::*;

    localparam int DRAIN_CYCLES = 20;     // well past the query latency
    localparam int HOLD_CYCLES  = 400;    // long receiver hold-off to back up the queue
    localparam int STUCK_LIMIT  = 5000;   // cycles with no transfer at all

    logic         i_clk     = 1'b0;
    logic         i_rst_n   = 1'b0;
    logic         s_valid   = 1'b0;
    logic [111:0] s_data    = '0;
    logic         s_user    = OP_WRITE;
    logic         m_ready   = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_index = CFG_GRID_WIDTH;
    logic [6:0]   cfg_data  = '0;

    logic         o_s_axis_tready;
    logic         o_m_axis_tvalid;
    logic [31:0]  o_m_axis_tdata;
    logic         o_cfg_ready;

    // idling mix of the current phase, in percent
    int send_idle_pct = 0;
    int stall_pct     = 0;

    // hold-off requests from the stimulus side, served by the receiver
    int hold_ask  = 0;
    int hold_seen = 0;
    int hold_left = 0;

    int stuck_cycles = 0;

    altitude_scoreboard sb = new();

    heightmap_triangle_sampler_core #(
        .GRID_MAX  (GRID_MAX),
        .FRAC_BITS (FRAC_BITS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        // tdata: write_index[12:0], write_value[44:13], query_x[76:45], query_y[108:77], pad
        .i_s_axis_tdata  (s_data),
        // tuser: opcode[0]
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        // tdata: altitude[31:0]
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // result side: check each transfer, then pick next cycle's tready
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && m_ready) sb.check_result(o_m_axis_tdata);
        if (hold_ask != hold_seen) begin
            hold_seen = hold_ask;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // any transfer on any channel counts as progress
    always @(posedge i_clk) begin
        if ((s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready) ||
            (cfg_valid && o_cfg_ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $error("no transfer for %0d cycles", STUCK_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // signed altitude: half full-range, half small so blends stay readable
    function automatic logic [31:0] rand_alt();
        logic [31:0] r;
        r = $urandom();
        if ($urandom_range(1)) r = {{12{r[19]}}, r[19:0]};
        return r;
    endfunction

    // fraction with its extremes weighted up
    function automatic logic [31:0] rand_frac();
        case ($urandom_range(3))
            0: return 32'd1;
            1: return ONE - 1;
            default: return $urandom_range(ONE - 1);
        endcase
    endfunction

    // one item on the slave stream, held until its transfer
    task automatic send_item(logic op, logic [12:0] idx, logic [31:0] val,
                             logic [31:0] qx, logic [31:0] qy);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= op;
        s_data  <= {3'b000, qy, qx, val, idx};
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_item(op, idx, val, qx, qy);
    endtask

    task automatic send_write(logic [12:0] idx, logic [31:0] val);
        send_item(OP_WRITE, idx, val, $urandom(), $urandom());
    endtask

    // any corner that was never loaded gets a write first, so no read hits an empty entry
    task automatic send_query(logic [31:0] qx, logic [31:0] qy);
        int unsigned nodes [$];
        sb.corner_nodes(qx, qy, nodes);
        foreach (nodes[k]) begin
            if (!sb.written[nodes[k]]) send_write(13'(nodes[k]), rand_alt());
        end
        send_item(OP_QUERY, 13'($urandom()), $urandom(), qx, qy);
    endtask

    // stop offering, wait for every owed altitude, then let in-flight writes settle
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // one register write, then the channel goes quiet
    task automatic write_cfg(logic idx, logic [6:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
        sb.set_dim(idx, val);
    endtask

    task automatic random_item();
        int unsigned pick;
        int unsigned node_cnt;
        logic [31:0] qx;
        logic [31:0] qy;
        pick     = $urandom_range(99);
        node_cnt = (sb.cells_x + 1) * (sb.cells_y + 1);
        if (pick < 5) begin
            // noise: any 13-bit index, mostly past the grid and dropped
            send_write(13'($urandom()), rand_alt());
        end else if (pick < 30) begin
            send_write(13'($urandom_range(node_cnt - 1)), rand_alt());
        end else begin
            case ($urandom_range(9))
                0: begin
                    // anywhere in the coordinate space, mostly clamped
                    qx = $urandom();
                    qy = $urandom();
                end
                1: begin
                    // on a node or on the border
                    qx = $urandom_range(sb.cells_x) << FRAC_BITS;
                    qy = $urandom_range(sb.cells_y) << FRAC_BITS;
                end
                2: begin
                    qx = $urandom_range(sb.cells_x << FRAC_BITS);
                    qy = $urandom_range(sb.cells_y << FRAC_BITS);
                end
                default: begin
                    qx = ($urandom_range(sb.cells_x - 1) << FRAC_BITS) | rand_frac();
                    qy = ($urandom_range(sb.cells_y - 1) << FRAC_BITS) | rand_frac();
                end
            endcase
            send_query(qx, qy);
        end
    endtask

    task automatic run_phase(logic [6:0] w_raw, logic [6:0] h_raw, int idle, int stall,
                             int items, bit hold, bit pause);
        drain();
        write_cfg(CFG_GRID_WIDTH, w_raw);
        write_cfg(CFG_GRID_HEIGHT, h_raw);
        send_idle_pct = idle;
        stall_pct     = stall;
        if (hold) hold_ask++;
        for (int n = 0; n < items; n++) begin
            if (pause && n == items / 2) drain();
            random_item();
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part on the reset grid of 64 by 64 cells
        send_write(13'd0, 32'h0000_0000);
        send_write(13'd1, 32'h7fff_ffff);
        send_write(13'd65, 32'h8000_0000);
        send_write(13'd66, 32'h0001_0000);
        send_write(13'd4224, 32'h1234_5678);
        send_write(13'd4225, 32'hdead_beef);    // one past the last node, dropped
        send_write(13'h1fff, 32'hffff_ffff);    // far out of range, dropped
        send_query(32'hffff_ffff, 32'hffff_ffff);   // negative, clamps to node 0
        send_query(32'h8000_0000, 32'h7fff_ffff);   // clamps to bottom-left corner
        send_query(32'h7fff_ffff, 32'h7fff_ffff);   // clamps to last node
        send_query(32'h0040_0000, 32'h0002_8000);   // on the right border
        send_query(32'h0000_0000, 32'h0000_8000);   // on the left border
        send_query(32'h0001_0000, 32'h0001_0000);   // exactly on an inner node
        // extreme corners, h1-h2 diagonal steeper
        send_query(32'h0000_8000, 32'h0000_4000);
        send_query(32'h0000_4000, 32'h0000_c000);
        send_query(32'h0000_ffff, 32'h0000_ffff);
        send_query(32'h0000_0001, 32'h0000_0001);
        // ramp where the h0-h3 diagonal is steeper
        send_write(13'd1, 32'h0001_0000);
        send_write(13'd65, 32'h0002_0000);
        send_write(13'd66, 32'h0007_0000);
        send_query(32'h0000_4000, 32'h0000_2000);
        send_query(32'h0000_c000, 32'h0000_e000);
        // equal diagonals, split goes along h1-h2
        send_write(13'd66, 32'h0003_0000);
        send_write(13'd65, 32'h0004_0000);
        send_query(32'h0000_8000, 32'h0000_8000);
        send_query(32'h0000_9000, 32'h0000_9000);

        // random phases across grid shapes and idling mixes
        run_phase(7'd64, 7'd64, 0, 0, 250, 1'b0, 1'b0);
        run_phase(7'd1, 7'd1, 88, 0, 200, 1'b0, 1'b0);
        run_phase(7'd0, 7'd127, 0, 88, 200, 1'b0, 1'b0);     // both saturate
        run_phase(7'd5, 7'd3, 14, 14, 350, 1'b0, 1'b0);
        run_phase(7'd127, 7'd0, 0, 0, 200, 1'b1, 1'b0);      // long hold-off, input backs up
        run_phase(7'd8, 7'd8, 14, 14, 300, 1'b0, 1'b1);      // sender pause midway
        run_phase(7'd64, 7'd64, 0, 88, 200, 1'b0, 1'b0);
        run_phase(7'd2, 7'd64, 0, 0, 200, 1'b0, 1'b0);
        run_phase(7'd64, 7'd1, 88, 88, 100, 1'b0, 1'b0);

        drain();
        sb.finish();
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
